// File: rtl/cbsb_pkg.sv
package cbsb_pkg;

   // three axes per point
   localparam int AXES = 3;

   // points-seen counter values
   localparam logic [1:0] SEEN_NONE = 2'd0;
   localparam logic [1:0] SEEN_EDGE = 2'd2;
   localparam logic [1:0] SEEN_FULL = 2'd3;

   // result slot of the output buffer, one-hot
   typedef enum logic [2:0] {
      SLOT_MID   = 3'b001,
      SLOT_THIRD = 3'b010,
      SLOT_TWO   = 3'b100
   } slot_type;

   // load command from the input stage to the output buffer
   typedef struct packed {
      logic emit;    // request produces results
      logic close;   // closing point: midpoint only, ends the curve
   } load_type;

endpackage

// File: rtl/cbsb_lane.sv
module cbsb_lane #(
   parameter int COORD_WIDTH = 24
) (
   input  logic signed [COORD_WIDTH-1:0] prior_point,
   input  logic signed [COORD_WIDTH-1:0] prior_two_thirds,
   input  logic signed [COORD_WIDTH-1:0] point,
   output logic signed [COORD_WIDTH-1:0] third,
   output logic signed [COORD_WIDTH-1:0] two_thirds,
   output logic signed [COORD_WIDTH-1:0] mid
);

   // biased difference width and exact reciprocal of 3 for that width
   localparam int KW = COORD_WIDTH + 2;
   localparam logic [KW+2:0] POW = {1'b1, {(KW+2){1'b0}}};
   localparam logic [KW+2:0] RECIP_FULL = (POW + (KW+3)'(2)) / 3;
   localparam logic [KW:0] RECIP = RECIP_FULL[KW:0];
   localparam logic [KW-1:0] BIAS = {2'b11, {COORD_WIDTH{1'b0}}};

   // base + floor((other - base) / 3)
   function automatic logic [COORD_WIDTH-1:0] near_third(
      input logic [COORD_WIDTH-1:0] base,
      input logic [COORD_WIDTH-1:0] other
   );
      logic [COORD_WIDTH:0] diff;
      logic [KW-1:0]        biased;
      logic [2*KW:0]        prod;
      logic [COORD_WIDTH:0] quot;
      logic [COORD_WIDTH:0] step;
      logic [COORD_WIDTH:0] total;
      diff   = {other[COORD_WIDTH-1], other} - {base[COORD_WIDTH-1], base};
      biased = {diff[COORD_WIDTH], diff} + BIAS;
      prod   = {{(KW+1){1'b0}}, biased} * {{KW{1'b0}}, RECIP};
      quot   = prod[2*KW:KW+2];
      step   = quot - {1'b1, {COORD_WIDTH{1'b0}}};
      total  = {base[COORD_WIDTH-1], base} + step;
      return total[COORD_WIDTH-1:0];
   endfunction

   logic [COORD_WIDTH:0] joint_sum;

   // edge one-third and two-thirds points
   assign third      = near_third(prior_point, point);
   assign two_thirds = near_third(point, prior_point);

   // floor midpoint of previous two-thirds point and new one-third point
   assign joint_sum = {prior_two_thirds[COORD_WIDTH-1], prior_two_thirds}
                    + {third[COORD_WIDTH-1], third};
   assign mid       = joint_sum[COORD_WIDTH:1];

endmodule

// File: rtl/cbsb_emit.sv
module cbsb_emit #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  cbsb_pkg::load_type                              load,
   input  logic [cbsb_pkg::AXES-1:0][COORD_WIDTH-1:0]      mid,
   input  logic [cbsb_pkg::AXES-1:0][COORD_WIDTH-1:0]      third,
   input  logic [cbsb_pkg::AXES-1:0][COORD_WIDTH-1:0]      two_thirds,
   output logic                                            ready,
   output logic                                            rsp_valid,
   input  logic                                            rsp_ready,
   output logic [cbsb_pkg::AXES-1:0][COORD_WIDTH-1:0]      bez,
   output logic                                            run_last,
   output logic                                            curve_end
);

   logic                                       valid_ff, valid_in;
   logic                                       close_ff, close_in;
   cbsb_pkg::slot_type                         slot_ff, slot_in;
   logic [cbsb_pkg::AXES-1:0][COORD_WIDTH-1:0] mid_ff, third_ff, two_ff;
   logic                                       take;
   logic                                       final_slot;

   // handshake on the result side
   assign take       = valid_ff & rsp_ready;
   assign final_slot = close_ff | (slot_ff == cbsb_pkg::SLOT_TWO);
   assign ready      = ~valid_ff | (take & final_slot);

   // slot sequencing
   always_comb begin
      valid_in = valid_ff;
      close_in = close_ff;
      slot_in  = slot_ff;
      if (load.emit) begin
         valid_in = 1'b1;
         close_in = load.close;
         slot_in  = cbsb_pkg::SLOT_MID;
      end else if (take) begin
         case (slot_ff)
            cbsb_pkg::SLOT_MID:   slot_in = cbsb_pkg::SLOT_THIRD;
            cbsb_pkg::SLOT_THIRD: slot_in = cbsb_pkg::SLOT_TWO;
            default:              slot_in = cbsb_pkg::SLOT_MID;
         endcase
         if (final_slot) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         close_ff <= 1'b0;
         slot_ff  <= cbsb_pkg::SLOT_MID;
      end else begin
         valid_ff <= valid_in;
         close_ff <= close_in;
         slot_ff  <= slot_in;
      end
   end

   // result points, captured with the request
   always_ff @(posedge clock) begin
      if (load.emit) begin
         mid_ff   <= mid;
         third_ff <= third;
         two_ff   <= two_thirds;
      end
   end

   // output selection
   always_comb begin
      case (slot_ff)
         cbsb_pkg::SLOT_MID:   bez = mid_ff;
         cbsb_pkg::SLOT_THIRD: bez = third_ff;
         cbsb_pkg::SLOT_TWO:   bez = two_ff;
         default:              bez = mid_ff;
      endcase
   end

   assign rsp_valid = valid_ff;
   assign run_last  = final_slot;
   assign curve_end = close_ff;

endmodule

// File: rtl/cubic_bspline_to_bezier_stream_core.sv
// Uniform cubic B-spline to Bezier converter. De Boor points of a curve come
// in one per request, the last one flagged by req_tlast; Bezier points leave
// on the rsp channel, with rsp_tlast on the final point caused by a request
// and rsp_tuser on the final point of the curve. A curve of n >= 4 points
// gives 3n-8 Bezier points; shorter curves give none. A request is
// registered, converted in one pass (one multiply by the reciprocal of 3 per
// axis and edge point) and loaded into a three-slot output buffer once that
// buffer is ready. The output buffer sets the rate: a request that yields
// three points occupies it until all three are taken; requests that yield
// one point or none pass at up to one per cycle while rsp_tready stays high.
// The next request is held and converted while the buffer drains.
module cubic_bspline_to_bezier_stream_core #(
   parameter  int COORD_WIDTH = 24,
   localparam int DATA_WIDTH  = ((cbsb_pkg::AXES * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_WIDTH-1:0] req_tdata,  // coord_x, coord_y, coord_z
   input  logic                  req_tlast,  // curve_last
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_WIDTH-1:0] rsp_tdata,  // bez_x, bez_y, bez_z
   output logic                  rsp_tlast,  // run_last
   output logic [0:0]            rsp_tuser   // curve_end
);

   localparam int PW = cbsb_pkg::AXES * COORD_WIDTH;

   logic                                       in_valid_ff, in_valid_in;
   logic [cbsb_pkg::AXES-1:0][COORD_WIDTH-1:0] in_point_ff;
   logic                                       in_last_ff;
   logic [cbsb_pkg::AXES-1:0][COORD_WIDTH-1:0] prior_point_ff;
   logic [cbsb_pkg::AXES-1:0][COORD_WIDTH-1:0] prior_two_ff;
   logic [1:0]                                 seen_ff, seen_in;
   logic [cbsb_pkg::AXES-1:0][COORD_WIDTH-1:0] third, two_thirds, mid;
   logic [cbsb_pkg::AXES-1:0][COORD_WIDTH-1:0] bez;
   logic                                       emit_ready;
   logic                                       req_take;
   logic                                       fire;
   logic                                       curve_end;
   cbsb_pkg::load_type                         load;

   // input register
   assign fire        = in_valid_ff & emit_ready;
   assign req_tready  = ~in_valid_ff | emit_ready;
   assign req_take    = req_tvalid & req_tready;
   assign in_valid_in = req_take | (in_valid_ff & ~fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_point_ff <= req_tdata[PW-1:0];
         in_last_ff  <= req_tlast;
      end
   end

   // per-axis edge and joint points
   for (genvar a = 0; a < cbsb_pkg::AXES; a++) begin : g_lane
      cbsb_lane #(
         .COORD_WIDTH(COORD_WIDTH)
      ) u_lane (
         .prior_point      (prior_point_ff[a]),
         .prior_two_thirds (prior_two_ff[a]),
         .point            (in_point_ff[a]),
         .third            (third[a]),
         .two_thirds       (two_thirds[a]),
         .mid              (mid[a])
      );
   end

   // result count from points seen
   always_comb begin
      load.close = in_last_ff;
      if (in_last_ff) begin
         load.emit = fire & (seen_ff == cbsb_pkg::SEEN_FULL);
      end else begin
         load.emit = fire & (seen_ff >= cbsb_pkg::SEEN_EDGE);
      end
   end

   // curve state
   always_comb begin
      seen_in = seen_ff;
      if (fire) begin
         if (in_last_ff) begin
            seen_in = cbsb_pkg::SEEN_NONE;
         end else if (seen_ff != cbsb_pkg::SEEN_FULL) begin
            seen_in = seen_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= cbsb_pkg::SEEN_NONE;
      end else begin
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && !in_last_ff) begin
         prior_point_ff <= in_point_ff;
         if (seen_ff != cbsb_pkg::SEEN_NONE) begin
            prior_two_ff <= two_thirds;
         end
      end
   end

   // output buffer
   cbsb_emit #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .mid        (mid),
      .third      (third),
      .two_thirds (two_thirds),
      .ready      (emit_ready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .bez        (bez),
      .run_last   (rsp_tlast),
      .curve_end  (curve_end)
   );

   assign rsp_tdata    = DATA_WIDTH'(bez);
   assign rsp_tuser[0] = curve_end;

endmodule
